### hdl/acmn_pkg.sv
package acmn_pkg;

  localparam int unsigned GainFracBitsDef = 12;
  localparam int unsigned SampleW         = 16;
  localparam int unsigned GainW           = 17;
  localparam int unsigned PeakW           = 16;
  localparam int unsigned QueueDepth      = 2;

  // At or below this peak the gain falls back to unity.
  localparam logic [PeakW-1:0] PeakFloor = PeakW'(32767 / 50);
  localparam logic [GainW-1:0] GainMax   = GainW'(65536);

  typedef enum logic [1:0] {
    ModeMono     = 2'd0,
    ModeStereo   = 2'd1,
    ModeSurround = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CfgInputStereo     = 2'd0,
    CfgOutputMode      = 2'd1,
    CfgNormalizeEnable = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] first_sample;
    logic signed [SampleW-1:0] second_sample;
    logic                      buffer_end;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_first;
    logic signed [SampleW-1:0] out_second;
    logic                      out_buffer_end;
  } out_word_t;

  typedef struct packed {
    logic  input_stereo;
    mode_e out_layout;
    logic  normalize_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [SampleW-1:0] mix_a;
    logic signed [SampleW-1:0] mix_b;
    logic                      buffer_end;
  } mix_word_t;

  typedef struct packed {
    logic             start;
    logic [PeakW-1:0] peak;
  } gain_req_t;

endpackage

### hdl/acmn_front.sv
module acmn_front (
  input  acmn_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  acmn_pkg::in_word_t  in_data_i,
  input  logic                q_ready_i,
  output logic                push_o,
  output acmn_pkg::mix_word_t mix_o
);
  import acmn_pkg::*;

  logic signed [SampleW-1:0] l_s, r_s, neg_l, half_s, surr_a, surr_b;
  logic signed [SampleW:0]   sum_s, sum_adj;
  logic signed [SampleW+2:0] l_x, r_x, ta, tb, ta_adj, tb_adj;

  always_comb begin
    l_s   = in_data_i.first_sample;
    r_s   = in_data_i.second_sample;
    neg_l = ~l_s + 16'sd1;

    // Halving and quartering truncate toward zero, so negative sums get a bias first.
    sum_s   = (SampleW+1)'(l_s) + (SampleW+1)'(r_s);
    sum_adj = sum_s + $signed({{SampleW{1'b0}}, sum_s[SampleW]});
    half_s  = sum_adj[SampleW:1];

    l_x    = (SampleW+3)'(l_s);
    r_x    = (SampleW+3)'(r_s);
    ta     = (l_x <<< 1) + l_x - r_x;
    tb     = (r_x <<< 1) + r_x - l_x;
    ta_adj = ta + $signed({{SampleW{1'b0}}, 1'b0, {2{ta[SampleW+2]}}});
    tb_adj = tb + $signed({{SampleW{1'b0}}, 1'b0, {2{tb[SampleW+2]}}});
    surr_a = ta_adj[SampleW+1:2];
    surr_b = tb_adj[SampleW+1:2];

    mix_o.mix_a      = '0;
    mix_o.mix_b      = '0;
    mix_o.buffer_end = in_data_i.buffer_end;
    if (cfg_i.input_stereo) begin
      unique case (cfg_i.out_layout)
        ModeMono: begin
          mix_o.mix_a = half_s;
        end
        ModeStereo: begin
          mix_o.mix_a = l_s;
          mix_o.mix_b = r_s;
        end
        ModeSurround: begin
          mix_o.mix_a = surr_a;
          mix_o.mix_b = surr_b;
        end
        default: begin
          mix_o.mix_a = '0;
        end
      endcase
    end else begin
      unique case (cfg_i.out_layout)
        ModeMono: begin
          mix_o.mix_a = l_s;
        end
        ModeStereo: begin
          mix_o.mix_a = l_s;
          mix_o.mix_b = l_s;
        end
        ModeSurround: begin
          mix_o.mix_a = l_s;
          mix_o.mix_b = neg_l;
        end
        default: begin
          mix_o.mix_a = '0;
        end
      endcase
    end
  end

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i & q_ready_i;

endmodule

### hdl/acmn_queue.sv
module acmn_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  acmn_pkg::mix_word_t data_i,
  output logic                ready_o,
  input  logic                pop_i,
  output logic                valid_o,
  output acmn_pkg::mix_word_t data_o
);
  import acmn_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  mix_word_t         mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign ready_o = (count_q != CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hdl/acmn_gain_div.sv
module acmn_gain_div #(
  parameter int unsigned GAIN_FRACTION_BITS = acmn_pkg::GainFracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  acmn_pkg::gain_req_t             req_i,
  output logic                            busy_o,
  output logic [acmn_pkg::GainW-1:0]      gain_o
);
  import acmn_pkg::*;

  localparam int unsigned DivW = GAIN_FRACTION_BITS + 15;
  localparam int unsigned CntW = $clog2(DivW + 1);
  localparam logic [DivW-1:0]  Dividend  = DivW'(32767) << GAIN_FRACTION_BITS;
  localparam logic [GainW-1:0] GainUnity = GainW'(1 << GAIN_FRACTION_BITS);

  typedef enum logic [1:0] {
    DivIdle = 2'b01,
    DivRun  = 2'b10
  } div_state_e;

  div_state_e        st_q, st_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DivW-1:0]   dvd_q, dvd_d, quo_q, quo_d;
  logic [PeakW-1:0]  rem_q, rem_d, dvs_q, dvs_d;
  logic [GainW-1:0]  gain_q, gain_d;
  logic [PeakW:0]    trial;
  logic              fits;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    gain_d = gain_q;
    trial  = {rem_q, dvd_q[DivW-1]};
    fits   = (trial >= {1'b0, dvs_q});
    unique case (st_q)
      DivIdle: begin
        if (req_i.start) begin
          if (req_i.peak > PeakFloor) begin
            dvs_d = req_i.peak;
            rem_d = '0;
            dvd_d = Dividend;
            quo_d = '0;
            cnt_d = CntW'(DivW);
            st_d  = DivRun;
          end else begin
            gain_d = GainUnity;
          end
        end
      end
      DivRun: begin
        rem_d = fits ? PeakW'(trial - {1'b0, dvs_q}) : trial[PeakW-1:0];
        quo_d = {quo_q[DivW-2:0], fits};
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          st_d = DivIdle;
          if (quo_d > DivW'(GainMax)) begin
            gain_d = GainMax;
          end else if (quo_d < DivW'(GainUnity)) begin
            gain_d = GainUnity;
          end else begin
            gain_d = quo_d[GainW-1:0];
          end
        end
      end
      default: begin
        st_d = DivIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= DivIdle;
      cnt_q  <= '0;
      gain_q <= GainUnity;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      gain_q <= gain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = (st_q == DivRun);
  assign gain_o = gain_q;

endmodule

### hdl/acmn_back.sv
module acmn_back #(
  parameter int unsigned GAIN_FRACTION_BITS = acmn_pkg::GainFracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  acmn_pkg::mix_word_t         q_data_i,
  output logic                        pop_o,
  input  logic                        normalize_i,
  input  logic [acmn_pkg::GainW-1:0]  gain_i,
  input  logic                        div_busy_i,
  output acmn_pkg::gain_req_t         req_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output acmn_pkg::out_word_t         out_data_o
);
  import acmn_pkg::*;

  localparam int unsigned ProdW = SampleW + GainW + 1;
  localparam logic signed [ProdW-1:0] RoundBias = ProdW'((1 << GAIN_FRACTION_BITS) - 1);
  localparam logic signed [ProdW-1:0] SatHi     = ProdW'(32767);
  localparam logic signed [ProdW-1:0] SatLo     = -ProdW'(32768);

  function automatic logic signed [SampleW-1:0] scale(input logic signed [SampleW-1:0] v,
                                                      input logic [GainW-1:0] g);
    logic signed [ProdW-1:0] prod;
    logic signed [ProdW-1:0] shr;
    prod = v * $signed({1'b0, g});
    if (prod[ProdW-1]) begin
      prod = prod + RoundBias;
    end
    shr = prod >>> GAIN_FRACTION_BITS;
    if (shr > SatHi) begin
      return 16'sh7fff;
    end else if (shr < SatLo) begin
      return 16'sh8000;
    end else begin
      return shr[SampleW-1:0];
    end
  endfunction

  function automatic logic [PeakW-1:0] mag(input logic signed [SampleW-1:0] v);
    return v[SampleW-1] ? PeakW'(~v + 16'sd1) : PeakW'(v);
  endfunction

  logic             out_valid_q, out_valid_d;
  out_word_t        out_data_q, out_data_d;
  logic [PeakW-1:0] peak_q, peak_d, mag_a, mag_b, peak_ab;
  logic             pop;

  assign pop = q_valid_i & ~div_busy_i & (~out_valid_q | out_ready_i);

  always_comb begin
    mag_a   = mag(q_data_i.mix_a);
    mag_b   = mag(q_data_i.mix_b);
    peak_ab = (mag_a > mag_b) ? mag_a : mag_b;
    peak_d  = peak_q;
    if (pop && normalize_i && (peak_ab > peak_q)) begin
      peak_d = peak_ab;
    end

    out_data_d.out_buffer_end = q_data_i.buffer_end;
    if (normalize_i) begin
      out_data_d.out_first  = scale(q_data_i.mix_a, gain_i);
      out_data_d.out_second = scale(q_data_i.mix_b, gain_i);
    end else begin
      out_data_d.out_first  = q_data_i.mix_a;
      out_data_d.out_second = q_data_i.mix_b;
    end

    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // The gain update sees the peak including this word.
    req_o.start = pop & normalize_i & q_data_i.buffer_end;
    req_o.peak  = peak_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      peak_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      peak_q      <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_data_q <= out_data_d;
    end
  end

  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hdl/audio_channel_mix_normalizer_top.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   in_data_i   (in_word_t)
// out      output     out_valid_o / out_ready_i out_data_o  (out_word_t)
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One word per cycle unless the output stalls or the divider is busy. Words are held
// in the queue, then in the output register. A buffer_end word with normalizing on and
// a peak above the floor starts the restoring gain divider, which holds the back end
// while it runs. A two-word queue parts the mixing front from the scaling back end, so
// input is taken while a result waits at the output. Reset is asynchronous, active low.
module audio_channel_mix_normalizer_top #(
  parameter int unsigned GAIN_FRACTION_BITS = acmn_pkg::GainFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  acmn_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output acmn_pkg::out_word_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [1:0]          cfg_data_i
);
  import acmn_pkg::*;

  cfg_t             cfg_q, cfg_d;
  mix_word_t        mix, q_data;
  logic             push, q_ready, q_valid, pop, div_busy;
  gain_req_t        gain_req;
  logic [GainW-1:0] gain;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgInputStereo:     cfg_d.input_stereo     = cfg_data_i[0];
        CfgOutputMode:      cfg_d.out_layout       = mode_e'(cfg_data_i);
        CfgNormalizeEnable: cfg_d.normalize_enable = cfg_data_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_stereo     <= 1'b0;
      cfg_q.out_layout       <= ModeStereo;
      cfg_q.normalize_enable <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  acmn_front u_front (
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .mix_o      (mix)
  );

  acmn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (mix),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  acmn_back #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .normalize_i (cfg_q.normalize_enable),
    .gain_i      (gain),
    .div_busy_i  (div_busy),
    .req_o       (gain_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  acmn_gain_div #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_gain_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (gain_req),
    .busy_o (div_busy),
    .gain_o (gain)
  );

endmodule

### hdl/acmn_checker.sv
module acmn_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input acmn_pkg::out_word_t out_data_o,
  input logic                cfg_ready_o
);

  // The output register is cleared by reset, so no word is offered right after it.
  a_reset_clears_out: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid while in reset");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped before it was taken");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("stalled output word changed");

  // Configuration writes are never back-pressured.
  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

  // Input ready stays known while a word waits to be taken.
  a_in_ready_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> !$isunknown(in_ready_o))
    else $error("input ready unknown");

endmodule

bind audio_channel_mix_normalizer_top acmn_checker u_acmn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);

### test/tb.sv
`timescale 1ns / 100ps

module tb;
  import acmn_pkg::*;

  localparam int unsigned GainFracBits  = GainFracBitsDef;
  localparam int          GainUnity     = 1 << GainFracBits;
  localparam logic [1:0]  ModeUnused    = 2'd3;
  localparam int          DrainCycles   = GainFracBits + 20;
  localparam int          WatchdogLimit = 2000;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_word_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [1:0]  cfg_data  = '0;

  // Words waiting to be sent and results the mixer still owes us.
  in_word_t    frame_q[$];
  out_word_t   owed_q[$];

  int          in_gap_max    = 12;
  int          out_stall_max = 12;
  int          in_gap        = 0;
  int          out_stall     = 0;
  int          mismatches    = 0;
  int          idle_cycles   = 0;

  // Shadow of the block's registers and state.
  logic        sh_stereo;
  logic [1:0]  sh_mode;
  logic        sh_norm;
  logic [15:0] peak_level;
  logic [16:0] gain;

  always #2 clk_i = ~clk_i;

  audio_channel_mix_normalizer_top #(
    .GAIN_FRACTION_BITS(GainFracBits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // Tracks the peak, then scales and saturates one sample.
  function automatic logic signed [15:0] apply_gain(int v);
    longint prod;
    if (v > int'(peak_level)) peak_level = 16'(v);
    if (v < -int'(peak_level)) peak_level = 16'(-v);
    prod = (longint'(v) * longint'(gain)) / longint'(GainUnity);
    if (prod > 32767) prod = 32767;
    if (prod < -32768) prod = -32768;
    return 16'(prod);
  endfunction

  function automatic void recompute_gain();
    longint g;
    if (peak_level > PeakFloor) g = (longint'(GainUnity) * 32767) / longint'(peak_level);
    else g = GainUnity;
    if (g > longint'(GainMax)) g = GainMax;
    if (g < GainUnity) g = GainUnity;
    gain = 17'(g);
  endfunction

  function automatic out_word_t mix_and_scale(in_word_t w);
    int l;
    int r;
    int a;
    int b;
    logic signed [15:0] neg;
    out_word_t res;
    l = w.first_sample;
    r = w.second_sample;
    a = 0;
    b = 0;
    if (sh_stereo) begin
      case (sh_mode)
        ModeMono: a = (l + r) / 2;
        ModeStereo: begin
          a = l;
          b = r;
        end
        ModeSurround: begin
          a = (3 * l - r) / 4;
          b = (3 * r - l) / 4;
        end
        default: ;
      endcase
    end else begin
      case (sh_mode)
        ModeMono: a = l;
        ModeStereo: begin
          a = l;
          b = l;
        end
        ModeSurround: begin
          // Negating the most negative sample wraps back onto itself.
          neg = 16'(-l);
          a = l;
          b = neg;
        end
        default: ;
      endcase
    end
    if (sh_norm) begin
      a = apply_gain(a);
      if (sh_mode != ModeMono) b = apply_gain(b);
      if (w.buffer_end) recompute_gain();
    end
    res.out_first      = a[15:0];
    res.out_second     = (sh_mode == ModeMono) ? '0 : b[15:0];
    res.out_buffer_end = w.buffer_end;
    return res;
  endfunction

  function automatic void add_frame(logic signed [15:0] a, logic signed [15:0] b, logic e);
    frame_q.push_back('{first_sample: a, second_sample: b, buffer_end: e});
  endfunction

  function automatic logic signed [15:0] pick_sample(int amp);
    int v;
    case ($urandom_range(0, 15))
      0: v = -amp;
      1: v = amp - 1;
      2: v = 0;
      default: v = int'($urandom_range(0, 2 * amp - 1)) - amp;
    endcase
    return 16'(v);
  endfunction

  // Polls on the falling edge so that all updates of the rising edge are settled.
  task automatic wait_results();
    @(negedge clk_i);
    while (frame_q.size() != 0 || in_valid || owed_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      CfgInputStereo:     sh_stereo = val[0];
      CfgOutputMode:      sh_mode   = val;
      CfgNormalizeEnable: sh_norm   = val[0];
      default: ;
    endcase
  endtask

  // The gain divider may still be busy after the last word left, so give it time.
  task automatic configure(logic stereo, logic [1:0] mode, logic norm);
    wait_results();
    repeat (DrainCycles) @(posedge clk_i);
    write_reg(CfgInputStereo, {1'b0, stereo});
    write_reg(CfgOutputMode, mode);
    write_reg(CfgNormalizeEnable, {1'b0, norm});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drv
    in_word_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) owed_q.push_back(mix_and_scale(in_data));
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (frame_q.size() != 0) begin
          nxt = frame_q.pop_front();
          in_data  <= nxt;
          in_valid <= 1'b1;
          in_gap   <= $urandom_range(0, in_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : mon
    out_word_t want;
    int stall;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: %0d %0d %0b", out_data.out_first,
                     out_data.out_second, out_data.out_buffer_end);
        end else begin
          want = owed_q.pop_front();
          if (out_data.out_first !== want.out_first ||
              out_data.out_second !== want.out_second ||
              out_data.out_buffer_end !== want.out_buffer_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                       want.out_first, want.out_second, want.out_buffer_end,
                       out_data.out_first, out_data.out_second, out_data.out_buffer_end);
          end
        end
        stall = $urandom_range(0, out_stall_max);
        out_stall <= stall;
        out_ready <= (stall == 0);
      end else if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_ready <= (out_stall == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stim
    int amp;
    sh_stereo  = 1'b0;
    sh_mode    = ModeStereo;
    sh_norm    = 1'b1;
    peak_level = '0;
    gain       = 17'(GainUnity);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Mono in, stereo out, normalizing: peak at the floor, just above it, saturation.
    add_frame(16'sd100, 16'sd32767, 1'b0);
    add_frame(-16'sd655, -16'sd32768, 1'b1);
    add_frame(16'sd656, 16'sd0, 1'b1);
    add_frame(16'sd10, 16'sd0, 1'b0);
    add_frame(-16'sd1, 16'sd0, 1'b0);
    add_frame(16'sd2500, 16'sd0, 1'b0);
    add_frame(-16'sd2600, 16'sd0, 1'b1);

    configure(1'b1, ModeSurround, 1'b0);
    add_frame(16'sd32767, -16'sd32768, 1'b0);
    add_frame(-16'sd32768, 16'sd32767, 1'b0);
    add_frame(-16'sd1, 16'sd0, 1'b0);
    add_frame(16'sd1, -16'sd2, 1'b0);
    add_frame(-16'sd32768, -16'sd32768, 1'b1);

    configure(1'b1, ModeMono, 1'b0);
    add_frame(16'sd32767, 16'sd32767, 1'b0);
    add_frame(-16'sd32768, -16'sd32768, 1'b0);
    add_frame(-16'sd1, 16'sd0, 1'b0);
    add_frame(-16'sd3, 16'sd0, 1'b1);

    configure(1'b0, ModeSurround, 1'b0);
    add_frame(-16'sd32768, 16'sd5, 1'b0);
    add_frame(16'sd32767, -16'sd1, 1'b0);
    add_frame(16'sd0, 16'sd0, 1'b1);

    configure(1'b0, ModeUnused, 1'b1);
    add_frame(16'sd1234, -16'sd4321, 1'b1);
    add_frame(-16'sd32768, 16'sd32767, 1'b0);

    configure(1'b1, ModeMono, 1'b1);
    add_frame(16'sd1000, 16'sd3000, 1'b1);

    // Every register setting; with normalizing on the amplitude grows so the gain
    // walks down as the peak rises.
    for (int p = 0; p < 16; p++) begin
      configure(p[1], 2'(p >> 2), p[0]);
      amp = p[0] ? 2048 + p * 2100 : 32768;
      if (amp > 32768) amp = 32768;
      in_gap_max    = (p % 3 == 0) ? 0 : 12;
      out_stall_max = (p % 4 == 1) ? 0 : 12;
      for (int i = 0; i < 60; i++) begin
        if (i == 30) wait_results();
        add_frame(pick_sample(amp), pick_sample(amp), $urandom_range(0, 7) == 0);
      end
    end

    // Full-scale input drives the peak to its top and the gain to its floor.
    configure(1'b0, ModeStereo, 1'b1);
    in_gap_max    = 12;
    out_stall_max = 0;
    for (int i = 0; i < 40; i++)
      add_frame(pick_sample(32768), pick_sample(32768), $urandom_range(0, 7) == 0);

    wait_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
hdl/acmn_pkg.sv
hdl/acmn_front.sv
hdl/acmn_queue.sv
hdl/acmn_gain_div.sv
hdl/acmn_back.sv
hdl/audio_channel_mix_normalizer_top.sv
hdl/acmn_checker.sv
test/tb.sv
